// ===== rtl/ndpc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ndpc_pkg
// shared types, codes and parameter defaults of the normalized decimated
// pss correlator
// ----------------------------------------------------------------------------
package ndpc_pkg;

    localparam int CODE_LEN_DEF     = 64;
    localparam int DECIM_DEF        = 2;
    localparam int NUM_CODES_DEF    = 3;
    localparam int SAMPLE_WIDTH_DEF = 16;

    localparam logic CMD_SAMPLE     = 1'b0;
    localparam logic CMD_CODE_WRITE = 1'b1;

    localparam logic REG_CODE_SELECT = 1'b0;
    localparam logic REG_CODE_AMP    = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_MUL,
        S_DRAIN,
        S_START,
        S_NORM,
        S_OUT
    } top_state_t;

    typedef enum logic [2:0] {
        OP_RR,
        OP_II,
        OP_IR,
        OP_RI,
        OP_PR,
        OP_PI
    } mac_op_t;

    typedef enum logic [2:0] {
        N_IDLE,
        N_SQR,
        N_DMUL,
        N_T1,
        N_T2,
        N_T3,
        N_SAT,
        N_DONE
    } norm_state_t;

    typedef struct packed {
        logic [15:0] corr;
        logic        zero;
        logic        sat;
    } norm_res_t;

endpackage

// ===== rtl/ndpc_norm.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ndpc_norm
// normalization unit: squares the correlation, scales the window power by
// the squared code amplitude and finds the quotient root bit by bit, all
// through one shared wide adder
// ----------------------------------------------------------------------------
module ndpc_norm #(
    parameter int AW = 39,
    parameter int PW = 38
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic signed [AW-1:0] cr,
    input  logic signed [AW-1:0] ci,
    input  logic [PW-1:0]        pw,
    input  logic [15:0]          amp,
    output logic                 done,
    output ndpc_pkg::norm_res_t  res
);
    import ndpc_pkg::*;

    localparam int RW   = 2 * AW + 17;
    localparam int TW   = (RW > PW + 66) ? RW : PW + 66;
    localparam int MPW  = (AW > 32) ? AW : 32;
    localparam int CNTW = $clog2(MPW + 1);

    norm_state_t state_reg, state_next;

    logic [TW-1:0]   r_reg, d_reg, e_reg, qd_reg, tmp_reg, mcand_reg;
    logic [MPW-1:0]  mplier_reg;
    logic [CNTW-1:0] cnt_reg;
    logic            phase_reg;
    logic [3:0]      k_reg;
    logic [15:0]     q_reg;
    norm_res_t       res_reg;

    logic [AW-1:0] cr_mag, ci_mag;
    logic [31:0]   amp2;
    logic [TW-1:0] add_a, add_b, sum;
    logic          le_hit, sat_hit;

    assign cr_mag  = cr[AW-1] ? $unsigned(-cr) : $unsigned(cr);
    assign ci_mag  = ci[AW-1] ? $unsigned(-ci) : $unsigned(ci);
    assign amp2    = {16'd0, amp} * {16'd0, amp};
    assign sum     = add_a + add_b;
    assign le_hit  = tmp_reg <= r_reg;
    assign sat_hit = (d_reg << 32) <= r_reg;
    assign res     = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= N_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            N_IDLE:
            begin
                if (start)
                begin
                    state_next = (pw == '0) ? N_DONE : N_SQR;
                end
            end
            N_SQR:
            begin
                if (cnt_reg == CNTW'(1) && phase_reg)
                begin
                    state_next = N_DMUL;
                end
            end
            N_DMUL:
            begin
                if (cnt_reg == CNTW'(1))
                begin
                    state_next = N_T1;
                end
            end
            N_T1:    state_next = N_T2;
            N_T2:    state_next = N_T3;
            N_T3:    state_next = (k_reg == 4'd0) ? N_SAT : N_T1;
            N_SAT:   state_next = N_DONE;
            N_DONE:  state_next = N_IDLE;
            default: state_next = N_IDLE;
        endcase
    end

    always_comb
    begin
        add_a = '0;
        add_b = '0;
        done  = 1'b0;
        case (state_reg)
            N_SQR:
            begin
                add_a = r_reg;
                add_b = mplier_reg[0] ? mcand_reg : '0;
            end
            N_DMUL:
            begin
                add_a = d_reg;
                add_b = mplier_reg[0] ? mcand_reg : '0;
            end
            N_T1:
            begin
                add_a = e_reg;
                add_b = qd_reg << ({1'b0, k_reg} + 5'd1);
            end
            N_T2:
            begin
                add_a = tmp_reg;
                add_b = d_reg << {k_reg, 1'b0};
            end
            N_T3:
            begin
                add_a = qd_reg;
                add_b = d_reg << k_reg;
            end
            N_DONE:  done = 1'b1;
            default:
            begin
                add_a = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            N_IDLE:
            begin
                if (start)
                begin
                    r_reg      <= '0;
                    mcand_reg  <= TW'(cr_mag);
                    mplier_reg <= MPW'(cr_mag);
                    cnt_reg    <= CNTW'(AW);
                    phase_reg  <= 1'b0;
                    if (pw == '0)
                    begin
                        res_reg <= '{corr: 16'd0, zero: 1'b1, sat: 1'b0};
                    end
                end
            end
            N_SQR:
            begin
                if (cnt_reg == CNTW'(1))
                begin
                    if (!phase_reg)
                    begin
                        r_reg      <= sum;
                        mcand_reg  <= TW'(ci_mag);
                        mplier_reg <= MPW'(ci_mag);
                        cnt_reg    <= CNTW'(AW);
                        phase_reg  <= 1'b1;
                    end
                    else
                    begin
                        r_reg      <= sum << 16;
                        mcand_reg  <= TW'(pw);
                        mplier_reg <= MPW'(amp2);
                        cnt_reg    <= CNTW'(32);
                        d_reg      <= '0;
                    end
                end
                else
                begin
                    r_reg      <= sum;
                    mcand_reg  <= mcand_reg << 1;
                    mplier_reg <= mplier_reg >> 1;
                    cnt_reg    <= cnt_reg - CNTW'(1);
                end
            end
            N_DMUL:
            begin
                d_reg <= sum;
                if (cnt_reg == CNTW'(1))
                begin
                    e_reg  <= '0;
                    qd_reg <= '0;
                    q_reg  <= '0;
                    k_reg  <= 4'd15;
                end
                else
                begin
                    mcand_reg  <= mcand_reg << 1;
                    mplier_reg <= mplier_reg >> 1;
                    cnt_reg    <= cnt_reg - CNTW'(1);
                end
            end
            N_T1:    tmp_reg <= sum;
            N_T2:    tmp_reg <= sum;
            N_T3:
            begin
                if (le_hit)
                begin
                    e_reg        <= tmp_reg;
                    qd_reg       <= sum;
                    q_reg[k_reg] <= 1'b1;
                end
                k_reg <= k_reg - 4'd1;
            end
            N_SAT:
            begin
                res_reg <= '{corr: q_reg, zero: 1'b0,
                             sat: (q_reg == 16'hFFFF) && sat_hit};
            end
            default:
            begin
                q_reg <= q_reg;
            end
        endcase
    end

endmodule

// ===== rtl/normalized_decimated_pss_correlator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// normalized_decimated_pss_correlator
// decimated cross-correlator of complex samples against a stored reference
// code, normalized by window power and code amplitude
// ----------------------------------------------------------------------------
// A code write, and a sample that does not yet fill the delay line, are
// accepted in the idle state. A sample that completes a window starts the
// correlation: the single multiplier forms six products per code tap after a
// registered memory read, then the shared adder of the normalization unit
// squares the sum, scales the power and extracts the 16-bit root bit by bit.
// The input is not ready during that time; the result waits in an output
// register.
module normalized_decimated_pss_correlator #(
    parameter int CODE_LEN     = ndpc_pkg::CODE_LEN_DEF,
    parameter int DECIM        = ndpc_pkg::DECIM_DEF,
    parameter int NUM_CODES    = ndpc_pkg::NUM_CODES_DEF,
    parameter int SAMPLE_WIDTH = ndpc_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // sample_re[15:0], sample_im[31:16], code_set[33:32], code_index[39:34],
    // code_re[55:40], code_im[71:56]
    input  logic [71:0] s_tdata,
    // cmd[0], first[1]
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // corr_norm[15:0], start_pos[39:16]
    output logic [39:0] m_tdata,
    // zero_power[0], saturated[1]
    output logic [1:0]  m_tuser,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import ndpc_pkg::*;

    localparam int SW       = SAMPLE_WIDTH;
    localparam int LINE_LEN = (CODE_LEN - 1) * DECIM + 1;
    localparam int LW       = $clog2(LINE_LEN);
    localparam int LW1      = LW + 1;
    localparam int FW       = $clog2(LINE_LEN + 1);
    localparam int TAPW     = $clog2(CODE_LEN);
    localparam int CDEPTH   = NUM_CODES * CODE_LEN;
    localparam int CADW     = $clog2(CDEPTH);
    localparam int OPW      = (SW > 16) ? SW : 16;
    localparam int AW       = SW + 17 + TAPW;
    localparam int PW       = 2 * SW + TAPW;

    top_state_t state_reg, state_next;

    logic [FW-1:0] fill_reg;
    logic [23:0]   pos_reg;
    logic [LW-1:0] line_wr_reg;
    logic [1:0]    code_select_reg;
    logic [15:0]   code_amp_reg;
    logic          m_tvalid_reg;
    logic          prod_vld_reg;

    logic [2*SW-1:0] line_mem [LINE_LEN];
    logic [31:0]     code_mem [CDEPTH];
    logic [2*SW-1:0] x_rd_reg;
    logic [31:0]     k_rd_reg;

    logic [TAPW-1:0]         tap_reg;
    logic [LW-1:0]           rd_idx_reg;
    mac_op_t                 sub_reg, prod_op_reg;
    logic signed [2*OPW-1:0] prod_reg;
    logic signed [AW-1:0]    acc_cr_reg, acc_ci_reg;
    logic [PW-1:0]           acc_pw_reg;
    logic [23:0]             start_pos_reg;

    logic [15:0] corr_out_reg;
    logic [23:0] pos_out_reg;
    logic        zero_out_reg, sat_out_reg;

    logic            s_acc, is_code, first, window_go, sample_go;
    logic [FW-1:0]   fill_base, fill_new;
    logic [23:0]     pos_base;
    logic [LW-1:0]   line_wr_next, rd_adv;
    logic [LW1-1:0]  rd_sum;
    logic [39:0]     re_ext, im_ext;
    logic            code_wr_ok;
    logic [CADW-1:0] code_wr_addr, code_rd_addr;
    logic [1:0]      sel;
    logic signed [SW-1:0]  xr, xi;
    logic signed [15:0]    kr, ki;
    logic signed [OPW-1:0] op_a, op_b;
    logic        norm_start, norm_done, out_load, cfg_wr;
    norm_res_t   norm_res;

    assign s_acc     = s_tvalid && s_tready;
    assign is_code   = s_tuser[0] == CMD_CODE_WRITE;
    assign first     = s_tuser[1];
    assign fill_base = first ? '0 : fill_reg;
    assign fill_new  = (fill_base < FW'(LINE_LEN)) ? fill_base + FW'(1) : fill_base;
    assign window_go = fill_new == FW'(LINE_LEN);
    assign sample_go = s_acc && !is_code;
    assign pos_base  = first ? 24'd0 : pos_reg;
    assign line_wr_next = (line_wr_reg == LW'(LINE_LEN - 1)) ? '0 : line_wr_reg + LW'(1);
    assign rd_sum    = {1'b0, rd_idx_reg} + LW1'(DECIM);
    assign rd_adv    = (rd_sum >= LW1'(LINE_LEN)) ? LW'(rd_sum - LW1'(LINE_LEN)) : LW'(rd_sum);
    assign re_ext    = {24'd0, s_tdata[15:0]};
    assign im_ext    = {24'd0, s_tdata[31:16]};
    assign code_wr_ok = ({1'b0, s_tdata[33:32]} < 3'(NUM_CODES))
                     && ({3'b000, s_tdata[39:34]} < 9'(CODE_LEN));
    assign code_wr_addr = CADW'(int'(s_tdata[33:32]) * CODE_LEN + int'(s_tdata[39:34]));
    assign sel = ({1'b0, code_select_reg} >= 3'(NUM_CODES)) ? 2'(NUM_CODES - 1)
                                                            : code_select_reg;
    assign code_rd_addr = CADW'(int'(sel) * CODE_LEN) + CADW'(tap_reg);
    assign xr = x_rd_reg[SW-1:0];
    assign xi = x_rd_reg[2*SW-1:SW];
    assign kr = k_rd_reg[15:0];
    assign ki = k_rd_reg[31:16];
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb
    begin
        op_a = OPW'(xr);
        op_b = OPW'(kr);
        case (sub_reg)
            OP_RR:
            begin
                op_a = OPW'(xr);
                op_b = OPW'(kr);
            end
            OP_II:
            begin
                op_a = OPW'(xi);
                op_b = OPW'(ki);
            end
            OP_IR:
            begin
                op_a = OPW'(xi);
                op_b = OPW'(kr);
            end
            OP_RI:
            begin
                op_a = OPW'(xr);
                op_b = OPW'(ki);
            end
            OP_PR:
            begin
                op_a = OPW'(xr);
                op_b = OPW'(xr);
            end
            OP_PI:
            begin
                op_a = OPW'(xi);
                op_b = OPW'(xi);
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (sample_go && window_go)
                begin
                    state_next = S_RD;
                end
            end
            S_RD:    state_next = S_MUL;
            S_MUL:
            begin
                if (sub_reg == OP_PI)
                begin
                    state_next = (tap_reg == TAPW'(CODE_LEN - 1)) ? S_DRAIN : S_RD;
                end
            end
            S_DRAIN: state_next = S_START;
            S_START: state_next = S_NORM;
            S_NORM:
            begin
                if (norm_done)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        s_tready   = state_reg == S_IDLE;
        norm_start = state_reg == S_START;
        out_load   = (state_reg == S_OUT) && (!m_tvalid_reg || m_tready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            fill_reg        <= '0;
            pos_reg         <= '0;
            line_wr_reg     <= '0;
            code_select_reg <= 2'd0;
            code_amp_reg    <= 16'd256;
            m_tvalid_reg    <= 1'b0;
            prod_vld_reg    <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            prod_vld_reg <= state_reg == S_MUL;
            if (sample_go)
            begin
                line_wr_reg <= line_wr_next;
                fill_reg    <= fill_new;
                pos_reg     <= window_go ? pos_base + 24'd1 : pos_base;
            end
            if (cfg_wr)
            begin
                case (paddr[2])
                    REG_CODE_SELECT: code_select_reg <= pwdata[1:0];
                    REG_CODE_AMP:    code_amp_reg    <= pwdata[15:0];
                    default:         code_amp_reg    <= code_amp_reg;
                endcase
            end
            if (out_load)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample_go)
        begin
            line_mem[line_wr_reg] <= {im_ext[SW-1:0], re_ext[SW-1:0]};
        end
        if (s_acc && is_code && code_wr_ok)
        begin
            code_mem[code_wr_addr] <= s_tdata[71:40];
        end
        if (state_reg == S_RD)
        begin
            x_rd_reg <= line_mem[rd_idx_reg];
            k_rd_reg <= code_mem[code_rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && sample_go && window_go)
        begin
            tap_reg       <= '0;
            rd_idx_reg    <= line_wr_next;
            acc_cr_reg    <= '0;
            acc_ci_reg    <= '0;
            acc_pw_reg    <= '0;
            start_pos_reg <= pos_base;
        end
        if (state_reg == S_RD)
        begin
            sub_reg <= OP_RR;
        end
        if (state_reg == S_MUL)
        begin
            prod_reg    <= op_a * op_b;
            prod_op_reg <= sub_reg;
            sub_reg     <= mac_op_t'(sub_reg + 3'd1);
            if (sub_reg == OP_PI)
            begin
                tap_reg    <= tap_reg + TAPW'(1);
                rd_idx_reg <= rd_adv;
            end
        end
        if (prod_vld_reg)
        begin
            case (prod_op_reg)
                OP_RR:   acc_cr_reg <= acc_cr_reg + AW'(prod_reg);
                OP_II:   acc_cr_reg <= acc_cr_reg + AW'(prod_reg);
                OP_IR:   acc_ci_reg <= acc_ci_reg + AW'(prod_reg);
                OP_RI:   acc_ci_reg <= acc_ci_reg - AW'(prod_reg);
                OP_PR:   acc_pw_reg <= acc_pw_reg + PW'(prod_reg);
                OP_PI:   acc_pw_reg <= acc_pw_reg + PW'(prod_reg);
                default: acc_pw_reg <= acc_pw_reg;
            endcase
        end
        if (out_load)
        begin
            corr_out_reg <= norm_res.corr;
            pos_out_reg  <= start_pos_reg;
            zero_out_reg <= norm_res.zero;
            sat_out_reg  <= norm_res.sat;
        end
    end

    ndpc_norm #(
        .AW (AW),
        .PW (PW)
    ) u_norm (
        .clk   (clk),
        .rst_n (rst_n),
        .start (norm_start),
        .cr    (acc_cr_reg),
        .ci    (acc_ci_reg),
        .pw    (acc_pw_reg),
        .amp   (code_amp_reg),
        .done  (norm_done),
        .res   (norm_res)
    );

    always_comb
    begin
        case (paddr[2])
            REG_CODE_SELECT: prdata = {30'd0, code_select_reg};
            REG_CODE_AMP:    prdata = {16'd0, code_amp_reg};
            default:         prdata = 32'd0;
        endcase
    end

    assign pready   = 1'b1;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {pos_out_reg, corr_out_reg};
    assign m_tuser  = {sat_out_reg, zero_out_reg};

    a_done_in_norm: assert property (@(posedge clk) disable iff (!rst_n)
        norm_done |-> state_reg == S_NORM)
        else $error("normalization done outside of its wait state");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FW'(LINE_LEN))
        else $error("fill count beyond line length");

    a_rd_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RD) |-> rd_idx_reg < LW'(LINE_LEN))
        else $error("line read index out of range");

    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (sample_go && window_go) |=> !s_tready)
        else $error("input ready while a window is being worked");

endmodule

// ===== tb/sv/normalized_decimated_pss_correlator_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// normalized_decimated_pss_correlator_tb
// self-checking testbench of the normalized decimated pss correlator: loads
// the three reference codes, streams directed and random sample blocks under
// several code_select / code_amp settings with random idling on both stream
// sides, and checks every result transaction against an in-bench predictor
// ----------------------------------------------------------------------------
module normalized_decimated_pss_correlator_tb;
    import ndpc_pkg::*;

    localparam int CODE_LEN  = CODE_LEN_DEF;
    localparam int DECIM     = DECIM_DEF;
    localparam int NUM_CODES = NUM_CODES_DEF;
    localparam int LINE_LEN  = (CODE_LEN - 1) * DECIM + 1;
    localparam int SETTLE    = 800;

    typedef struct packed {
        logic        cmd;
        logic        first;
        logic [71:0] data;
    } stream_item_t;

    typedef struct packed {
        logic [15:0] corr_norm;
        logic [23:0] start_pos;
        logic        zero_power;
        logic        saturated;
    } corr_result_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [71:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    stream_item_t pending_items[$];
    corr_result_t expected_corr[$];
    stream_item_t item_on_bus;

    logic signed [15:0] line_re[LINE_LEN];
    logic signed [15:0] line_im[LINE_LEN];
    logic signed [15:0] code_re_mem[NUM_CODES][CODE_LEN];
    logic signed [15:0] code_im_mem[NUM_CODES][CODE_LEN];
    int unsigned        fill_level;
    logic [23:0]        window_pos;
    int unsigned        line_wr;
    logic [1:0]         sel_shadow;
    logic [15:0]        amp_shadow;

    int  send_gap;
    int  recv_gap;
    bit  no_idle;
    int  results_seen;
    bit  long_hold_done;
    int  mismatches;

    normalized_decimated_pss_correlator i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int idle_length();
        int r;
        r = $urandom_range(99);
        if (no_idle || r < 60)
            return 0;
        else if (r < 95)
            return $urandom_range(4, 1);
        return $urandom_range(100, 20);
    endfunction

    // appends one transaction to the driver queue
    function automatic void queue_item(stream_item_t it);
        pending_items = {pending_items, it};
    endfunction

    function automatic stream_item_t sample_item(logic first, logic [15:0] re, logic [15:0] im);
        stream_item_t it;
        it.cmd         = CMD_SAMPLE;
        it.first       = first;
        it.data        = 72'({$urandom, $urandom, $urandom});
        it.data[15:0]  = re;
        it.data[31:16] = im;
        return it;
    endfunction

    function automatic stream_item_t code_item(logic [1:0] set, logic [5:0] idx,
                                               logic [15:0] re, logic [15:0] im);
        stream_item_t it;
        it.cmd          = CMD_CODE_WRITE;
        it.first        = 1'($urandom_range(1));
        it.data         = 72'({$urandom, $urandom, $urandom});
        it.data[33:32]  = set;
        it.data[39:34]  = idx;
        it.data[55:40]  = re;
        it.data[71:56]  = im;
        return it;
    endfunction

    // updates the shadow state for one accepted transaction and queues any predicted result
    function void correlate_item(stream_item_t it);
        longint      cr, ci, pw, xr, xi, kr, ki;
        bit [127:0]  ur, ui, corr_sq, trial, pw128, amp2;
        int unsigned sel, idx;
        logic [15:0] q;
        corr_result_t res;
        if (it.cmd == CMD_CODE_WRITE) begin
            if (it.data[33:32] < NUM_CODES && it.data[39:34] < CODE_LEN)
            begin
                code_re_mem[it.data[33:32]][it.data[39:34]] = it.data[55:40];
                code_im_mem[it.data[33:32]][it.data[39:34]] = it.data[71:56];
            end
            return;
        end
        if (it.first) begin
            fill_level = 0;
            window_pos = '0;
        end
        line_re[line_wr] = it.data[15:0];
        line_im[line_wr] = it.data[31:16];
        line_wr = (line_wr + 1) % LINE_LEN;
        if (fill_level < LINE_LEN)
            fill_level++;
        if (fill_level < LINE_LEN)
            return;
        sel = (sel_shadow < NUM_CODES) ? sel_shadow : NUM_CODES - 1;
        cr = 0;
        ci = 0;
        pw = 0;
        for (int i = 0; i < CODE_LEN; i++) begin
            idx = (line_wr + i * DECIM) % LINE_LEN;
            xr = line_re[idx];
            xi = line_im[idx];
            kr = code_re_mem[sel][i];
            ki = code_im_mem[sel][i];
            cr += xr * kr + xi * ki;
            ci += xi * kr - xr * ki;
            pw += xr * xr + xi * xi;
        end
        res.start_pos = window_pos;
        window_pos++;
        res.zero_power = 1'b0;
        res.saturated  = 1'b0;
        res.corr_norm  = '0;
        if (pw == 0) begin
            res.zero_power = 1'b1;
        end else begin
            ur = (cr < 0) ? -cr : cr;
            ui = (ci < 0) ? -ci : ci;
            corr_sq = (ur * ur + ui * ui) << 16;
            pw128 = pw;
            amp2 = amp_shadow * amp_shadow;
            q = '0;
            for (int b = 15; b >= 0; b--) begin
                trial = q | (16'h1 << b);
                if (trial * trial * amp2 * pw128 <= corr_sq)
                    q[b] = 1'b1;
            end
            res.corr_norm = q;
            if (q == 16'hFFFF && ((amp2 << 32) * pw128 <= corr_sq))
                res.saturated = 1'b1;
        end
        expected_corr = {expected_corr, res};
    endfunction

    // stream driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= '0;
            send_gap  = 0;
        end else begin
            if (s_tvalid && s_tready)
                correlate_item(item_on_bus);
            if (!s_tvalid || s_tready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end else if (pending_items.size() > 0) begin
                    item_on_bus = pending_items.pop_front();
                    s_tdata  <= item_on_bus.data;
                    s_tuser  <= {item_on_bus.first, item_on_bus.cmd};
                    s_tvalid <= 1'b1;
                    send_gap  = idle_length();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver back-pressure, with one long hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            m_tready      <= 1'b0;
            recv_gap       = 0;
            long_hold_done = 1'b0;
        end else if (!long_hold_done && results_seen == 200) begin
            long_hold_done = 1'b1;
            recv_gap       = 5000;
            m_tready      <= 1'b0;
        end else if (recv_gap > 0) begin
            recv_gap--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            recv_gap  = idle_length();
        end
    end

    // result monitor
    always @(posedge clk or negedge rst_n)
    begin
        corr_result_t want;
        corr_result_t got;
        if (!rst_n) begin
            results_seen = 0;
            mismatches   = 0;
        end else if (m_tvalid && m_tready) begin
            got = {m_tdata[15:0], m_tdata[39:16], m_tuser[0], m_tuser[1]};
            results_seen++;
            if (expected_corr.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result transaction %h", got);
            end else begin
                want = expected_corr.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: corr %h/%h pos %h/%h zero %b/%b sat %b/%b",
                                 want.corr_norm, got.corr_norm, want.start_pos,
                                 got.start_pos, want.zero_power, got.zero_power,
                                 want.saturated, got.saturated);
                end
            end
        end
    end

    task automatic reg_write(logic addr_sel, logic [31:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {addr_sel, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr_sel == REG_CODE_SELECT)
            sel_shadow = value[1:0];
        else
            amp_shadow = value[15:0];
    endtask

    task automatic wait_drained();
        while (pending_items.size() > 0 || s_tvalid || expected_corr.size() > 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic configure(logic [1:0] sel, logic [15:0] amp);
        wait_drained();
        reg_write(REG_CODE_SELECT, 32'(sel));
        reg_write(REG_CODE_AMP, 32'(amp));
    endtask

    // random block; correlated blocks follow the selected code's taps
    task automatic random_block(int count, int style);
        int unsigned sel, tap, sh;
        logic [15:0] re, im;
        sel = (sel_shadow < NUM_CODES) ? sel_shadow : NUM_CODES - 1;
        sh  = $urandom_range(3);
        for (int k = 0; k < count; k++) begin
            if ($urandom_range(19) == 0) begin
                queue_item(code_item(2'($urandom_range(3)), 6'($urandom),
                                     16'($urandom), 16'($urandom)));
                continue;
            end
            tap = (k / DECIM) % CODE_LEN;
            case (style)
                0: begin
                    re = 16'($urandom);
                    im = 16'($urandom);
                end
                1: begin
                    re = (code_re_mem[sel][tap] >>> sh) + $signed(4'($urandom));
                    im = (code_im_mem[sel][tap] >>> sh) + $signed(4'($urandom));
                end
                default: begin
                    re = $signed(3'($urandom));
                    im = $signed(3'($urandom));
                end
            endcase
            queue_item(sample_item($urandom_range(399) == 0, re, im));
        end
    endtask

    initial
    begin
        int sent;
        rst_n   = 1'b0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        no_idle = 1'b0;
        fill_level = 0;
        window_pos = '0;
        line_wr    = 0;
        sel_shadow = '0;
        amp_shadow = 16'd256;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // full load of every code, with an ignored out-of-range write
        configure(2'd0, 16'd256);
        for (int c = 0; c < NUM_CODES; c++)
            for (int i = 0; i < CODE_LEN; i++)
                queue_item(code_item(2'(c), 6'(i),
                    (c == 1) ? ((i % 3 == 0) ? 16'h8000 : 16'h7FFF) : 16'($urandom),
                    (c == 1) ? 16'h7FFF : 16'($urandom)));
        queue_item(code_item(2'd3, 6'd5, 16'h1234, 16'h4321));

        // zero-power windows, then extreme samples, then a restart
        no_idle = 1'b1;
        for (int k = 0; k < LINE_LEN + 4; k++)
            queue_item(sample_item(k == 0, 16'h0000, 16'h0000));
        for (int k = 0; k < 24; k++)
            queue_item(sample_item(1'b0, k[0] ? 16'h8000 : 16'h7FFF,
                                   k[1] ? 16'h8000 : 16'h7FFF));
        queue_item(sample_item(1'b1, 16'h7FFF, 16'h8000));
        wait_drained();
        no_idle = 1'b0;

        // tiny amplitude saturates, code_select beyond range, zero amplitude
        configure(2'd1, 16'd1);
        random_block(160, 1);
        configure(2'd3, 16'hFFFF);
        random_block(160, 0);
        configure(2'd2, 16'd0);
        random_block(160, 1);

        sent = 0;
        while (sent < 1100) begin
            configure(2'($urandom_range(3)), ($urandom_range(3) == 0) ?
                      16'($urandom_range(1) ? 16'hFFFF : 16'd1) : 16'($urandom));
            no_idle = ($urandom_range(4) == 0);
            random_block(220, $urandom_range(2));
            sent += 220;
        end

        wait_drained();
        if (mismatches == 0 && expected_corr.size() == 0)
            $display("** normalized_decimated_pss_correlator: PASSED **");
        else
            $display("** normalized_decimated_pss_correlator: FAILED **");
        $finish;
    end

    initial
    begin
        #200_000_000;
        $display("** normalized_decimated_pss_correlator: FAILED **");
        $finish;
    end

endmodule
